### hw/rtl/pcsw_pkg.sv
// pcsw_pkg: shared types, codes and constants for the PCI class search walker.
// Depends on nothing; imported by pcsw_urom, pcsw_stack and pci_class_search_walker.
package pcsw_pkg;

  // Channel payloads
  typedef struct packed {
    logic        op;
    logic [31:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bus_number;
    logic [4:0] device_number;
    logic [2:0] function_number;
    logic [7:0] register_offset;
    logic [3:0] found_count;
    logic       last_of_run;
  } out_item_t;

  // Input operation codes
  localparam logic OP_START    = 1'b0;
  localparam logic OP_RESPONSE = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_MATCH = 2'd1;
  localparam logic [1:0] KIND_DONE  = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_CLASS_CODE    = 2'd0;
  localparam logic [1:0] REG_SUBCLASS_CODE = 2'd1;
  localparam logic [1:0] REG_PROG_IF       = 2'd2;
  localparam logic [1:0] REG_MATCH_LIMIT   = 2'd3;

  // Config space offsets
  localparam logic [7:0] OFF_VENDOR    = 8'd0;
  localparam logic [7:0] OFF_CLASS     = 8'd8;
  localparam logic [7:0] OFF_HEADER    = 8'd12;
  localparam logic [7:0] OFF_SECONDARY = 8'd24;

  localparam logic [15:0] VENDOR_NONE  = 16'hFFFF;
  localparam int          HDR_MF_BIT   = 23;        // multifunction bit of the header dword
  localparam logic [15:0] BRIDGE_CLASS = 16'h0604;
  localparam logic [7:0]  PROG_IF_ANY  = 8'hFF;
  localparam logic [4:0]  LAST_DEVICE  = 5'd31;
  localparam logic [2:0]  LAST_FUNCTION = 3'd7;

  localparam int MAX_MATCHES     = 8;
  localparam int DEF_BUS_COUNT   = 256;
  localparam int DEF_STACK_DEPTH = 256;

  // Reset values of the configuration registers
  localparam logic [7:0] RST_PROG_IF     = 8'd255;
  localparam logic [3:0] RST_MATCH_LIMIT = 4'd8;

  // Walk phase: which read the next response answers
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DEV_VENDOR,
    PH_HEADER,
    PH_FN_VENDOR,
    PH_CLASS,
    PH_SECONDARY
  } phase_t;

  // Return stack frame
  typedef struct packed {
    logic [7:0] bus;
    logic [4:0] dev;
    logic [2:0] fn;
    logic       multi;
  } frame_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } stack_ctl_t;

  // Microcode
  typedef logic [4:0] uaddr_t;

  typedef enum logic [3:0] {
    C_NEXT,          // fall through
    C_ALWAYS,
    C_DISPATCH,      // wait for a transaction, then branch on op and phase
    C_LIMIT_HIT,
    C_VENDOR_NONE,
    C_NO_MATCH,
    C_NOT_BRIDGE,
    C_NO_DESCEND,
    C_MORE_FN,
    C_NO_MORE_DEV,
    C_STACK_EMPTY
  } cond_t;

  typedef enum logic [3:0] {
    D_NONE,
    D_START,
    D_HEADER,
    D_INC_FN,
    D_INC_DEV,
    D_INC_MATCH,
    D_PUSH,
    D_POP_RD,
    D_POP_LOAD
  } dp_t;

  typedef enum logic [1:0] {
    E_NONE,
    E_READ,
    E_MATCH,
    E_DONE
  } emit_t;

  typedef struct packed {
    cond_t      cond;
    uaddr_t     target;
    dp_t        dp;
    emit_t      emit;
    logic [7:0] offset;
    phase_t     phase;
    logic       last;
  } uword_t;

  // Program entry points
  localparam uaddr_t U_IDLE       = 5'd0;
  localparam uaddr_t U_START      = 5'd1;
  localparam uaddr_t U_START_LIM  = 5'd2;
  localparam uaddr_t U_EMIT_DEV   = 5'd3;
  localparam uaddr_t U_DONE       = 5'd4;
  localparam uaddr_t U_EMIT_FN    = 5'd5;
  localparam uaddr_t U_DEV_VENDOR = 5'd6;
  localparam uaddr_t U_DEV_HDR_RD = 5'd7;
  localparam uaddr_t U_HEADER     = 5'd8;
  localparam uaddr_t U_FN_VENDOR  = 5'd9;
  localparam uaddr_t U_FN_CLS_RD  = 5'd10;
  localparam uaddr_t U_CLASS      = 5'd11;
  localparam uaddr_t U_CLS_COUNT  = 5'd12;
  localparam uaddr_t U_CLS_REPORT = 5'd13;
  localparam uaddr_t U_CLASS_LIM  = 5'd14;
  localparam uaddr_t U_CLS_BRIDGE = 5'd15;
  localparam uaddr_t U_CLS_SEC_RD = 5'd16;
  localparam uaddr_t U_SECONDARY  = 5'd17;
  localparam uaddr_t U_SEC_PUSH   = 5'd18;
  localparam uaddr_t U_ADV_FN     = 5'd19;
  localparam uaddr_t U_ADV_FN_CHK = 5'd20;
  localparam uaddr_t U_ADV_DEV    = 5'd21;
  localparam uaddr_t U_ADV_DEV_CHK = 5'd22;
  localparam uaddr_t U_ADV_DEV_INC = 5'd23;
  localparam uaddr_t U_POP        = 5'd24;
  localparam uaddr_t U_POP_RD     = 5'd25;
  localparam uaddr_t U_POP_LOAD   = 5'd26;
  localparam uaddr_t U_FN_STEP    = 5'd27;

endpackage

### hw/rtl/pcsw_urom.sv
// pcsw_urom: read-only control store of the walker sequencer.
// Depends on pcsw_pkg (uword_t, entry points, condition, datapath and emit codes).
module pcsw_urom import pcsw_pkg::*; (
  input  uaddr_t upc,
  output uword_t uword
);

  function automatic uword_t mk(cond_t c, uaddr_t t, dp_t d, emit_t e,
                                logic [7:0] off, phase_t ph, logic last);
    uword_t w;
    w.cond   = c;
    w.target = t;
    w.dp     = d;
    w.emit   = e;
    w.offset = off;
    w.phase  = ph;
    w.last   = last;
    return w;
  endfunction

  always_comb begin
    case (upc)
      U_IDLE:        uword = mk(C_DISPATCH, U_IDLE, D_NONE, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_START:       uword = mk(C_NEXT, U_IDLE, D_START, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_START_LIM:   uword = mk(C_LIMIT_HIT, U_DONE, D_NONE, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_EMIT_DEV:    uword = mk(C_ALWAYS, U_IDLE, D_NONE, E_READ, OFF_VENDOR,
                                PH_DEV_VENDOR, 1'b1);
      U_DONE:        uword = mk(C_ALWAYS, U_IDLE, D_NONE, E_DONE, OFF_VENDOR, PH_IDLE, 1'b1);
      U_EMIT_FN:     uword = mk(C_ALWAYS, U_IDLE, D_NONE, E_READ, OFF_VENDOR,
                                PH_FN_VENDOR, 1'b1);
      U_DEV_VENDOR:  uword = mk(C_VENDOR_NONE, U_ADV_DEV, D_NONE, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_DEV_HDR_RD:  uword = mk(C_ALWAYS, U_IDLE, D_NONE, E_READ, OFF_HEADER, PH_HEADER, 1'b1);
      U_HEADER:      uword = mk(C_ALWAYS, U_EMIT_FN, D_HEADER, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_FN_VENDOR:   uword = mk(C_VENDOR_NONE, U_ADV_FN, D_NONE, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_FN_CLS_RD:   uword = mk(C_ALWAYS, U_IDLE, D_NONE, E_READ, OFF_CLASS, PH_CLASS, 1'b1);
      U_CLASS:       uword = mk(C_NO_MATCH, U_CLASS_LIM, D_NONE, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_CLS_COUNT:   uword = mk(C_NEXT, U_IDLE, D_INC_MATCH, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_CLS_REPORT:  uword = mk(C_NEXT, U_IDLE, D_NONE, E_MATCH, OFF_VENDOR, PH_IDLE, 1'b0);
      U_CLASS_LIM:   uword = mk(C_LIMIT_HIT, U_DONE, D_NONE, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_CLS_BRIDGE:  uword = mk(C_NOT_BRIDGE, U_ADV_FN, D_NONE, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_CLS_SEC_RD:  uword = mk(C_ALWAYS, U_IDLE, D_NONE, E_READ, OFF_SECONDARY,
                                PH_SECONDARY, 1'b1);
      U_SECONDARY:   uword = mk(C_NO_DESCEND, U_ADV_FN, D_NONE, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_SEC_PUSH:    uword = mk(C_ALWAYS, U_EMIT_DEV, D_PUSH, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_ADV_FN:      uword = mk(C_LIMIT_HIT, U_DONE, D_NONE, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_ADV_FN_CHK:  uword = mk(C_MORE_FN, U_FN_STEP, D_NONE, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_ADV_DEV:     uword = mk(C_LIMIT_HIT, U_DONE, D_NONE, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_ADV_DEV_CHK: uword = mk(C_NO_MORE_DEV, U_POP, D_NONE, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_ADV_DEV_INC: uword = mk(C_ALWAYS, U_EMIT_DEV, D_INC_DEV, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_POP:         uword = mk(C_STACK_EMPTY, U_DONE, D_NONE, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_POP_RD:      uword = mk(C_NEXT, U_IDLE, D_POP_RD, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
      U_POP_LOAD:    uword = mk(C_ALWAYS, U_ADV_FN, D_POP_LOAD, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      U_FN_STEP:     uword = mk(C_ALWAYS, U_EMIT_FN, D_INC_FN, E_NONE, OFF_VENDOR,
                                PH_IDLE, 1'b0);
      default:       uword = mk(C_ALWAYS, U_IDLE, D_NONE, E_NONE, OFF_VENDOR, PH_IDLE, 1'b0);
    endcase
  end

endmodule

### hw/rtl/pcsw_stack.sv
// pcsw_stack: return stack of bridge frames, one memory with a registered pop port.
// Depends on pcsw_pkg (frame_t, stack_ctl_t).
module pcsw_stack import pcsw_pkg::*; #(
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  stack_ctl_t ctl,
  input  frame_t     push_frame,
  output frame_t     pop_frame,
  output logic       empty,
  output logic       full
);

  localparam int SP_W  = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  logic [SP_W-1:0] sp;
  logic [SP_W-1:0] sp_dec;
  frame_t          mem [STACK_DEPTH];

  assign sp_dec = sp - SP_W'(1);
  assign empty  = (sp == '0);
  assign full   = (sp == SP_W'(STACK_DEPTH));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sp <= '0;
    end else if (ctl.push) begin
      sp <= sp + SP_W'(1);
    end else if (ctl.pop) begin
      sp <= sp_dec;
    end
  end

  // Write at the top, read the frame below the top on a pop
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[sp[IDX_W-1:0]] <= push_frame;
    end
    if (ctl.pop) begin
      pop_frame <= mem[sp_dec[IDX_W-1:0]];
    end
  end

`ifndef SYNTHESIS
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> !empty)
    else $error("pop of an empty return stack");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    ctl.push |-> !full)
    else $error("push onto a full return stack");

  a_push_pop_excl: assert property (@(posedge clk) disable iff (rst)
    !(ctl.push && ctl.pop))
    else $error("push and pop in the same cycle");
`endif

endmodule

### hw/rtl/pci_class_search_walker.sv
// pci_class_search_walker: depth-first PCI config space walk that reports functions
// of a given class. Depends on pcsw_pkg, pcsw_urom and pcsw_stack.
//
//  channel   direction  handshake               payload
//  --------  ---------  ----------------------  --------------------------------------
//  in        to block   in_valid / in_ready     in_item  (op, read_data)
//  out       from block out_valid / out_ready   out_item (kind, bdf, offset, count, last)
//  cfg       to block   cfg_we (no wait)        cfg_index, cfg_data
//
// Sequencer: one control word per cycle unless a result step stalls, from acceptance
// of a transaction to its last result, also while frames are popped off the return stack.
// Reset: synchronous, active high; prog_interface to 255, match_limit to 8, then a
// clearing pass over the visited tags, repeated on each start that wraps the epoch.
// Stalls: a result step waits while the output register is full and out_ready is low;
// in_ready is high only at the idle word while no clearing pass runs.
module pci_class_search_walker import pcsw_pkg::*; #(
  parameter int BUS_COUNT   = DEF_BUS_COUNT,
  parameter int STACK_DEPTH = DEF_STACK_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  localparam int              BUS_IDX_W = $clog2(BUS_COUNT);
  localparam int              EPOCH_W   = 8;
  localparam logic [6:0]      MaxLimit  = 7'(MAX_MATCHES);
  localparam logic [8:0]      BusLimit  = 9'(BUS_COUNT);
  localparam logic [EPOCH_W-1:0] EpochTop = '1;

  // Configuration registers
  logic [7:0] class_code;
  logic [7:0] subclass_code;
  logic [7:0] prog_interface;
  logic [3:0] match_limit;

  // Sequencer
  uaddr_t upc;
  uaddr_t upc_next;
  uword_t uw;
  logic   stall;
  logic   take;
  uaddr_t dispatch;

  // Walk state
  logic [7:0]           bus;
  logic [4:0]           dev;
  logic [2:0]           fn;
  logic                 multi;
  logic [3:0]           match_count;
  phase_t               phase;
  logic [31:0]          data;

  // Visited map: one epoch tag per bus
  logic [EPOCH_W-1:0]   visit_mem [BUS_COUNT];
  logic [EPOCH_W-1:0]   epoch;
  logic [EPOCH_W-1:0]   sec_tag;
  logic [BUS_IDX_W-1:0] clear_addr;
  logic                 clearing;

  // Stack interface
  stack_ctl_t stack_ctl;
  frame_t     push_frame;
  frame_t     pop_frame;
  logic       stack_empty;
  logic       stack_full;

  // Conditions
  logic [3:0] limit_eff;
  logic       limit_hit;
  logic       vendor_none;
  logic       class_match;
  logic       is_bridge;
  logic [7:0] sec;
  logic       sec_in_range;
  logic       descend;
  logic       more_fn;
  logic       no_more_dev;

  out_item_t out_next;

  pcsw_urom u_urom (
    .upc   (upc),
    .uword (uw)
  );

  pcsw_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk        (clk),
    .rst        (rst),
    .ctl        (stack_ctl),
    .push_frame (push_frame),
    .pop_frame  (pop_frame),
    .empty      (stack_empty),
    .full       (stack_full)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      class_code     <= '0;
      subclass_code  <= '0;
      prog_interface <= RST_PROG_IF;
      match_limit    <= RST_MATCH_LIMIT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CLASS_CODE:    class_code     <= cfg_data;
        REG_SUBCLASS_CODE: subclass_code  <= cfg_data;
        REG_PROG_IF:       prog_interface <= cfg_data;
        REG_MATCH_LIMIT:   match_limit    <= cfg_data[3:0];
        default:           ;
      endcase
    end
  end

  // Condition logic; the response checks are evaluated on the latched response dword
  assign limit_eff    = ({3'b0, match_limit} > MaxLimit) ? MaxLimit[3:0] : match_limit;
  assign limit_hit    = (match_count >= limit_eff);
  assign vendor_none  = (data[15:0] == VENDOR_NONE);
  assign class_match  = (data[31:24] == class_code) && (data[23:16] == subclass_code) &&
                        ((prog_interface == PROG_IF_ANY) || (data[15:8] == prog_interface));
  assign is_bridge    = (data[31:16] == BRIDGE_CLASS);
  assign sec          = data[15:8];
  assign sec_in_range = ({1'b0, sec} < BusLimit);
  // Descend only into a fresh secondary bus that fits the map and the stack;
  // a bus is visited when its tag carries the epoch of the running search
  assign descend      = (sec != 8'd0) && (sec != bus) && sec_in_range &&
                        (sec_tag != epoch) && !stack_full;
  assign more_fn      = multi && (fn != LAST_FUNCTION);
  assign no_more_dev  = (dev == LAST_DEVICE);

  always_comb begin
    case (uw.cond)
      C_NEXT:        take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_LIMIT_HIT:   take = limit_hit;
      C_VENDOR_NONE: take = vendor_none;
      C_NO_MATCH:    take = !class_match;
      C_NOT_BRIDGE:  take = !is_bridge;
      C_NO_DESCEND:  take = !descend;
      C_MORE_FN:     take = more_fn;
      C_NO_MORE_DEV: take = no_more_dev;
      C_STACK_EMPTY: take = stack_empty;
      default:       take = 1'b0;
    endcase
  end

  // Entry point for an accepted transaction; a response while idle is dropped
  always_comb begin
    if (in_item.op == OP_START) begin
      dispatch = U_START;
    end else begin
      case (phase)
        PH_DEV_VENDOR: dispatch = U_DEV_VENDOR;
        PH_HEADER:     dispatch = U_HEADER;
        PH_FN_VENDOR:  dispatch = U_FN_VENDOR;
        PH_CLASS:      dispatch = U_CLASS;
        PH_SECONDARY:  dispatch = U_SECONDARY;
        default:       dispatch = U_IDLE;
      endcase
    end
  end

  // Hold the step while its result cannot enter the output register
  assign stall    = (uw.emit != E_NONE) && out_valid && !out_ready;
  assign in_ready = (upc == U_IDLE) && !clearing;

  always_comb begin
    if (stall) begin
      upc_next = upc;
    end else if (uw.cond == C_DISPATCH) begin
      upc_next = (in_valid && !clearing) ? dispatch : U_IDLE;
    end else if (take) begin
      upc_next = uw.target;
    end else begin
      upc_next = upc + 5'd1;
    end
  end

  // Result formed from the walk state as it stands at the emitting step
  always_comb begin
    out_next                 = '0;
    out_next.found_count     = match_count;
    out_next.last_of_run     = uw.last;
    case (uw.emit)
      E_READ: begin
        out_next.kind            = KIND_READ;
        out_next.bus_number      = bus;
        out_next.device_number   = dev;
        out_next.function_number = fn;
        out_next.register_offset = uw.offset;
      end
      E_MATCH: begin
        out_next.kind            = KIND_MATCH;
        out_next.bus_number      = bus;
        out_next.device_number   = dev;
        out_next.function_number = fn;
      end
      E_DONE: begin
        out_next.kind = KIND_DONE;
      end
      default: ;
    endcase
  end

  // Sequencer, phase and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      upc       <= U_IDLE;
      phase     <= PH_IDLE;
      out_valid <= 1'b0;
    end else begin
      upc <= upc_next;
      if (!stall && (uw.emit != E_NONE)) begin
        out_valid <= 1'b1;
        out_item  <= out_next;
        if (uw.emit == E_READ) begin
          phase <= uw.phase;
        end else if (uw.emit == E_DONE) begin
          phase <= PH_IDLE;
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch the response dword on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= in_item.read_data;
    end
  end

  // Epoch of the running search; advance on every start, and on wrap sweep all
  // tags back to zero before the next transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      epoch      <= '0;
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      if (clear_addr == BUS_IDX_W'(BUS_COUNT - 1)) begin
        clearing   <= 1'b0;
        clear_addr <= '0;
      end else begin
        clear_addr <= clear_addr + BUS_IDX_W'(1);
      end
    end else if (uw.dp == D_START) begin
      if (epoch == EpochTop) begin
        epoch    <= EPOCH_W'(1);
        clearing <= 1'b1;
      end else begin
        epoch <= epoch + EPOCH_W'(1);
      end
    end
  end

  // Tag memory: write on a push or a sweep, read the secondary bus tag as the
  // response is accepted so it is ready at the descend check
  always_ff @(posedge clk) begin
    if (clearing) begin
      visit_mem[clear_addr] <= '0;
    end else if (uw.dp == D_PUSH) begin
      visit_mem[sec[BUS_IDX_W-1:0]] <= epoch;
    end
    if (in_valid && in_ready) begin
      sec_tag <= visit_mem[in_item.read_data[8 +: BUS_IDX_W]];
    end
  end

  // Stack control and frame of the current function
  assign stack_ctl.clear   = (uw.dp == D_START);
  assign stack_ctl.push    = (uw.dp == D_PUSH);
  assign stack_ctl.pop     = (uw.dp == D_POP_RD);
  assign push_frame.bus    = bus;
  assign push_frame.dev    = dev;
  assign push_frame.fn     = fn;
  assign push_frame.multi  = multi;

  // Datapath operations; steps without a result never stall
  always_ff @(posedge clk) begin
    if (rst) begin
      bus         <= '0;
      dev         <= '0;
      fn          <= '0;
      multi       <= 1'b0;
      match_count <= '0;
    end else if (!stall) begin
      case (uw.dp)
        D_START: begin
          bus         <= '0;
          dev         <= '0;
          fn          <= '0;
          multi       <= 1'b0;
          match_count <= '0;
        end
        D_HEADER: begin
          multi <= data[HDR_MF_BIT];
          fn    <= '0;
        end
        D_INC_FN: begin
          fn <= fn + 3'd1;
        end
        D_INC_DEV: begin
          dev   <= dev + 5'd1;
          fn    <= '0;
          multi <= 1'b0;
        end
        D_INC_MATCH: begin
          match_count <= match_count + 4'd1;
        end
        D_PUSH: begin
          bus   <= sec;
          dev   <= '0;
          fn    <= '0;
          multi <= 1'b0;
        end
        D_POP_LOAD: begin
          // Resume at the bridge function; the advance steps move past it
          bus   <= pop_frame.bus;
          dev   <= pop_frame.dev;
          fn    <= pop_frame.fn;
          multi <= pop_frame.multi;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_match_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_item.kind == KIND_MATCH)) |-> !out_item.last_of_run)
    else $error("match result marked as last of its run");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (!stall && (uw.emit != E_NONE) && uw.last) |=> (upc == U_IDLE))
    else $error("sequencer not idle after the last result of a transaction");

  a_start_dispatch: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && (in_item.op == OP_START)) |=> (upc == U_START))
    else $error("start transaction did not enter the start routine");

  a_done_idles_phase: assert property (@(posedge clk) disable iff (rst)
    (!stall && (uw.emit == E_DONE)) |=> (phase == PH_IDLE))
    else $error("walk phase not idle after a done result");
`endif

endmodule
